// ===== hw/rtl/ste_pkg.sv =====
`default_nettype none

package ste_pkg;

  localparam int TICK_W     = 39;
  localparam int COUNT_W    = 7;
  localparam int INDEX_W    = 6;
  localparam int MS_W       = 32;
  localparam int DIVIDEND_W = 49;
  localparam int DIV_CNT_W  = 6;
  localparam int STEP_W     = 3;
  localparam int CODE_W     = 3;

  // Restoring division walks one dividend bit per step.
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  // Microprogram step addresses.
  localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SCALE  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIVIDE = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;

  // Datapath actions.
  localparam logic [CODE_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] ACT_ACCEPT = 3'd1;
  localparam logic [CODE_W-1:0] ACT_LOAD   = 3'd2;
  localparam logic [CODE_W-1:0] ACT_DIV    = 3'd3;
  localparam logic [CODE_W-1:0] ACT_EMIT   = 3'd4;

  // Jump conditions.
  localparam logic [CODE_W-1:0] COND_NONE     = 3'd0;
  localparam logic [CODE_W-1:0] COND_NO_ENTRY = 3'd1;
  localparam logic [CODE_W-1:0] COND_RUN_DONE = 3'd2;
  localparam logic [CODE_W-1:0] COND_DIV_BUSY = 3'd3;
  localparam logic [CODE_W-1:0] COND_OUT_BUSY = 3'd4;

  typedef struct packed {
    logic [CODE_W-1:0] act;
    logic [CODE_W-1:0] cond;
    logic [STEP_W-1:0] jump;
    logic [STEP_W-1:0] next;
  } ctrl_word_t;

  // The control store: jump when the condition holds, else go to next.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      STEP_FETCH:  w = '{ACT_ACCEPT, COND_NO_ENTRY, STEP_FETCH,  STEP_CHECK};
      STEP_CHECK:  w = '{ACT_NONE,   COND_RUN_DONE, STEP_FETCH,  STEP_SCALE};
      STEP_SCALE:  w = '{ACT_LOAD,   COND_NONE,     STEP_SCALE,  STEP_DIVIDE};
      STEP_DIVIDE: w = '{ACT_DIV,    COND_DIV_BUSY, STEP_DIVIDE, STEP_EMIT};
      STEP_EMIT:   w = '{ACT_EMIT,   COND_OUT_BUSY, STEP_EMIT,   STEP_CHECK};
      default:     w = '{ACT_NONE,   COND_NONE,     STEP_FETCH,  STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sample_time_run_expander.sv =====
// Expands run-length time-to-sample entries into one start time per sample.
// Entry channel (entry_valid/entry_stall): new_table, sample_count and
// tick_delta. Sample channel (sample_valid/sample_stall): start_ms,
// chapter_index, last_of_run and list_full. Each side moves a request when
// valid is high and stall is low. cfg_write loads the timescale register
// from cfg_data; write it only while the block is idle.
// A small microprogram drives the datapath. An entry is taken in the fetch
// step, then each sample takes a run check, a scaling by 1000, a
// one-bit-per-cycle restoring divide over all 49 dividend bits, and the
// emit step. An entry yielding no samples returns the sequencer to the
// fetch step after the run check.
// The result sits in an output register, so the divider keeps working on
// the next sample while a result is stalled; the emit step waits only when
// the register is still full. Reset empties the output register, returns
// the sequencer to the fetch step, clears the tick total and chapter count
// and sets the timescale to 1000.
`default_nettype none

module sample_time_run_expander #(
  parameter int unsigned MAX_CHAPTERS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data,
  input  wire logic        entry_valid,
  output logic             entry_stall,
  input  wire logic        new_table,
  input  wire logic [31:0] sample_count,
  input  wire logic [31:0] tick_delta,
  output logic             sample_valid,
  input  wire logic        sample_stall,
  output logic [31:0]      start_ms,
  output logic [5:0]       chapter_index,
  output logic             last_of_run,
  output logic             list_full
);

  localparam logic [ste_pkg::COUNT_W-1:0] CAP = ste_pkg::COUNT_W'(MAX_CHAPTERS);

  logic [ste_pkg::STEP_W-1:0]     pc;
  logic [ste_pkg::STEP_W-1:0]     pc_next;
  ste_pkg::ctrl_word_t            cw;
  logic                           cond_hit;

  logic [31:0]                    timescale;
  logic [ste_pkg::TICK_W-1:0]     tick_total;
  logic [ste_pkg::COUNT_W-1:0]    chapters_found;
  logic [ste_pkg::COUNT_W-1:0]    found_inc;
  logic [31:0]                    run_left;
  logic [31:0]                    delta;

  logic [ste_pkg::DIVIDEND_W-1:0] dividend;
  logic [ste_pkg::DIVIDEND_W-1:0] scaled;
  logic [31:0]                    rem;
  logic [32:0]                    trial;
  logic                           q_bit;
  logic [31:0]                    quotient;
  logic [ste_pkg::DIV_CNT_W-1:0]  div_left;

  logic                           out_busy;
  logic                           run_done;
  logic                           do_emit;

  assign cw          = ste_pkg::ucode(pc);
  assign entry_stall = (cw.act != ste_pkg::ACT_ACCEPT);
  assign out_busy    = sample_valid && sample_stall;
  assign run_done    = (run_left == 32'd0) || (chapters_found >= CAP);
  assign found_inc   = chapters_found + ste_pkg::COUNT_W'(1);
  assign do_emit     = (cw.act == ste_pkg::ACT_EMIT) && !out_busy;

  // tick_total * 1000 as 1024 - 16 - 8 times the total.
  always_comb begin
    scaled = (ste_pkg::DIVIDEND_W'(tick_total) << 10)
           - (ste_pkg::DIVIDEND_W'(tick_total) << 4)
           - (ste_pkg::DIVIDEND_W'(tick_total) << 3);
  end

  assign trial = {rem, dividend[ste_pkg::DIVIDEND_W-1]};
  assign q_bit = (trial >= {1'b0, timescale});

  always_comb begin
    case (cw.cond)
      ste_pkg::COND_NO_ENTRY: cond_hit = !entry_valid;
      ste_pkg::COND_RUN_DONE: cond_hit = run_done;
      ste_pkg::COND_DIV_BUSY: cond_hit = (div_left != '0);
      ste_pkg::COND_OUT_BUSY: cond_hit = out_busy;
      default:                cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? cw.jump : cw.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= ste_pkg::STEP_FETCH;
      timescale      <= 32'd1000;
      tick_total     <= '0;
      chapters_found <= '0;
      sample_valid   <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_write) begin
        timescale <= cfg_data;
      end
      if ((cw.act == ste_pkg::ACT_ACCEPT) && entry_valid && new_table) begin
        tick_total     <= '0;
        chapters_found <= '0;
      end
      if (do_emit) begin
        tick_total     <= tick_total + ste_pkg::TICK_W'(delta);
        chapters_found <= found_inc;
        sample_valid   <= 1'b1;
      end else if (sample_valid && !sample_stall) begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (cw.act)
      ste_pkg::ACT_ACCEPT: begin
        if (entry_valid) begin
          run_left <= sample_count;
          delta    <= tick_delta;
        end
      end
      ste_pkg::ACT_LOAD: begin
        dividend <= scaled;
        rem      <= '0;
        div_left <= ste_pkg::DIV_LAST;
      end
      ste_pkg::ACT_DIV: begin
        dividend <= dividend << 1;
        rem      <= q_bit ? 32'(trial - {1'b0, timescale}) : trial[31:0];
        quotient <= {quotient[30:0], q_bit};
        if (div_left != '0) begin
          div_left <= div_left - ste_pkg::DIV_CNT_W'(1);
        end
      end
      ste_pkg::ACT_EMIT: begin
        if (!out_busy) begin
          run_left      <= run_left - 32'd1;
          start_ms      <= quotient;
          chapter_index <= chapters_found[ste_pkg::INDEX_W-1:0];
          last_of_run   <= (run_left == 32'd1) || (found_inc >= CAP);
          list_full     <= (found_inc >= CAP);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    chapters_found <= CAP)
    else $error("chapter count passed capacity");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && list_full) |->
      (chapter_index == ste_pkg::INDEX_W'(MAX_CHAPTERS - 1)))
    else $error("full flag on a result that is not the last chapter");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ((pc == ste_pkg::STEP_EMIT) && !out_busy) |=>
      (sample_valid && (pc == ste_pkg::STEP_CHECK)))
    else $error("emit step did not load the output register");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    ((pc == ste_pkg::STEP_DIVIDE) && (div_left == '0)) |=> (pc == ste_pkg::STEP_EMIT))
    else $error("divider did not hand over to the emit step");
`endif

endmodule

`default_nettype wire

// ===== verif/sample_time_run_expander_checker.sv =====
module sample_time_run_expander_checker #(
  parameter int unsigned MAX_CHAPTERS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [31:0]                cfg_data,
  input  logic                       entry_valid,
  input  logic                       entry_stall,
  input  logic                       new_table,
  input  logic [31:0]                sample_count,
  input  logic [31:0]                tick_delta,
  input  logic                       sample_valid,
  input  logic                       sample_stall,
  input  logic [ste_pkg::MS_W-1:0]    start_ms,
  input  logic [ste_pkg::INDEX_W-1:0] chapter_index,
  input  logic                       last_of_run,
  input  logic                       list_full,
  output int unsigned                mismatches,
  output int unsigned                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ste_pkg::MS_W-1:0]    start_ms;
    logic [ste_pkg::INDEX_W-1:0] chapter_index;
    logic                        last_of_run;
    logic                        list_full;
  } sample_time_t;

  sample_time_t                  samples_due[$];
  logic [31:0]                   ticks_per_second;
  logic [ste_pkg::TICK_W-1:0]    tick_sum;
  logic [ste_pkg::COUNT_W-1:0]   chapters;

  function automatic logic [31:0] ticks_to_msec(input logic [ste_pkg::TICK_W-1:0] ticks,
                                                input logic [31:0] scale);
    logic [63:0] product;
    if (scale == '0) begin
      return '1;
    end
    product = 64'(ticks) * 64'd1000;
    return 32'(product / 64'(scale));
  endfunction

  // Runs longer than the room left in the chapter list are cut short, and the
  // samples that are dropped do not advance the tick sum.
  task automatic expand_run(input logic nt, input logic [31:0] cnt, input logic [31:0] dlt);
    int unsigned  room;
    int unsigned  emit;
    int unsigned  k;
    sample_time_t s;
    if (nt) begin
      tick_sum = '0;
      chapters = '0;
    end
    room = (chapters < MAX_CHAPTERS) ? MAX_CHAPTERS - chapters : 0;
    emit = (cnt < room) ? cnt : room;
    for (k = 0; k < emit; k++) begin
      s.start_ms      = ticks_to_msec(tick_sum, ticks_per_second);
      s.chapter_index = chapters[ste_pkg::INDEX_W-1:0];
      chapters        = chapters + 1'b1;
      s.last_of_run   = (k + 1 == emit);
      s.list_full     = (chapters >= MAX_CHAPTERS);
      samples_due.push_back(s);
      tick_sum = tick_sum + ste_pkg::TICK_W'(dlt);
    end
  endtask

  always @(posedge clk) begin
    sample_time_t want;
    if (rst) begin
      ticks_per_second = 32'd1000;
      tick_sum         = '0;
      chapters         = '0;
      mismatches       = 0;
      samples_due.delete();
    end else begin
      if (sample_valid && !sample_stall) begin
        if (samples_due.size() == 0) begin
          $error("unexpected sample: start_ms %0h chapter_index %0d", start_ms, chapter_index);
          mismatches++;
        end else begin
          want = samples_due.pop_front();
          if (start_ms !== want.start_ms) begin
            $error("start_ms: expected %0h, actual %0h", want.start_ms, start_ms);
            mismatches++;
          end
          if (chapter_index !== want.chapter_index) begin
            $error("chapter_index: expected %0d, actual %0d", want.chapter_index,
                   chapter_index);
            mismatches++;
          end
          if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last_of_run);
            mismatches++;
          end
          if (list_full !== want.list_full) begin
            $error("list_full: expected %0b, actual %0b", want.list_full, list_full);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        ticks_per_second = cfg_data;
      end
      if (entry_valid && !entry_stall) begin
        expand_run(new_table, sample_count, tick_delta);
      end
    end
    outstanding = samples_due.size();
  end

endmodule

// ===== verif/sample_time_run_expander_tb.sv =====
module sample_time_run_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CHAPTERS   = 64;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 23;

  logic                        clk           = 1'b0;
  logic                        rst           = 1'b1;
  logic                        cfg_write     = 1'b0;
  logic [31:0]                 cfg_data      = '0;
  logic                        entry_valid   = 1'b0;
  logic                        entry_stall;
  logic                        new_table     = 1'b0;
  logic [31:0]                 sample_count  = '0;
  logic [31:0]                 tick_delta    = '0;
  logic                        sample_valid;
  logic                        sample_stall  = 1'b0;
  logic [ste_pkg::MS_W-1:0]    start_ms;
  logic [ste_pkg::INDEX_W-1:0] chapter_index;
  logic                        last_of_run;
  logic                        list_full;
  logic                        calm          = 1'b0;
  int unsigned                 mismatches;
  int unsigned                 outstanding;

  sample_time_run_expander #(
    .MAX_CHAPTERS(MAX_CHAPTERS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .entry_valid  (entry_valid),
    .entry_stall  (entry_stall),
    .new_table    (new_table),
    .sample_count (sample_count),
    .tick_delta   (tick_delta),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .start_ms     (start_ms),
    .chapter_index(chapter_index),
    .last_of_run  (last_of_run),
    .list_full    (list_full)
  );

  sample_time_run_expander_checker #(
    .MAX_CHAPTERS(MAX_CHAPTERS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .entry_valid  (entry_valid),
    .entry_stall  (entry_stall),
    .new_table    (new_table),
    .sample_count (sample_count),
    .tick_delta   (tick_delta),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .start_ms     (start_ms),
    .chapter_index(chapter_index),
    .last_of_run  (last_of_run),
    .list_full    (list_full),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall bursts alternate with stretches where every sample is taken.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        sample_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        sample_stall <= 1'b0;
      end else if (!calm) begin
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (entry_valid && !entry_stall) || (sample_valid && !sample_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("sample_time_run_expander: mismatch");
    $finish;
  end

  function automatic logic [31:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return '0;
    end else if (r < 80) begin
      return $urandom_range(1, 6);
    end else if (r < 92) begin
      return $urandom_range(7, 40);
    end
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return '0;
    end else if (r < 25) begin
      return 32'hFFFF_FFFF - $urandom_range(0, 15);
    end else if (r < 60) begin
      return $urandom_range(1, 5000);
    end
    return $urandom();
  endfunction

  // Valid stays high from one request to the next unless a gap is drawn.
  task automatic send_entry(input logic nt, input logic [31:0] cnt, input logic [31:0] dlt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      entry_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    entry_valid  <= 1'b1;
    new_table    <= nt;
    sample_count <= cnt;
    tick_delta   <= dlt;
    do @(posedge clk); while (entry_stall);
  endtask

  // An entry that yields no samples can still be in flight when the last
  // expected sample has come, so a few extra cycles pass before going on.
  task automatic wait_idle();
    entry_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timescale(input logic [31:0] scale);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed tables: a restart followed by a few runs, with an
  // occasional stray restart in the middle.
  task automatic run_tables(input int unsigned items);
    int unsigned sent;
    int unsigned runs;
    int unsigned k;
    sent = 0;
    while (sent < items) begin
      runs = $urandom_range(1, 8);
      send_entry(1'b1, pick_count(), pick_delta());
      sent++;
      for (k = 1; k < runs && sent < items; k++) begin
        send_entry($urandom_range(0, 15) == 0, pick_count(), pick_delta());
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] scale;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timescale of 1000 ticks per second.
    send_entry(1'b1, 32'd0, 32'hFFFF_FFFF);
    send_entry(1'b0, 32'd1, 32'd0);
    send_entry(1'b0, 32'd3, 32'hFFFF_FFFF);
    send_entry(1'b0, 32'd0, 32'd5);
    send_entry(1'b0, 32'd2, 32'd1000);
    // Fill the list in one run, then knock on a full list.
    send_entry(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_entry(1'b0, 32'd5, 32'd7);
    send_entry(1'b0, 32'hFFFF_FFFF, 32'd1);
    send_entry(1'b1, 32'd60, 32'd12345);
    send_entry(1'b0, 32'd10, 32'd1);
    send_entry(1'b0, 32'd1, 32'd1);

    // One tick per second makes the millisecond value wrap past 32 bits.
    set_timescale(32'd1);
    send_entry(1'b1, 32'd64, 32'hFFFF_FFFF);
    send_entry(1'b1, 32'd2, 32'h8000_0000);

    set_timescale(32'hFFFF_FFFF);
    send_entry(1'b1, 32'd3, 32'hFFFF_FFFF);
    send_entry(1'b0, 32'd1, 32'h5555_5555);

    set_timescale(32'd90000);
    run_tables(PHASE_ITEMS);
    scale = $urandom();
    if (scale == '0) begin
      scale = 32'd1;
    end
    set_timescale(scale);
    run_tables(PHASE_ITEMS);
    set_timescale(32'd1);
    run_tables(PHASE_ITEMS);
    set_timescale(32'd44100);
    run_tables(PHASE_ITEMS);
    set_timescale(32'hFFFF_FFFF);
    calm <= 1'b1;
    run_tables(PHASE_ITEMS);

    entry_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outstanding != 0) begin
      $error("%0d expected samples never arrived", outstanding);
    end
    if (mismatches == 0 && outstanding == 0) begin
      $display("sample_time_run_expander: match");
    end else begin
      $display("sample_time_run_expander: mismatch");
    end
    $finish;
  end

endmodule
